// File: hw/rtl/mpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mpq_pkg;

    // key width and default depth of the cell chain
    localparam int KEY_W        = 32;
    localparam int CAPACITY_DEF = 64;

    // operation codes carried on i_op
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef logic signed [KEY_W-1:0] t_key;

    // broadcast to every cell in the chain
    typedef struct packed {
        logic ins;      // insert the broadcast key this cycle
        logic rem;      // shift toward the head, dropping the head key
        t_key key;      // key being inserted
    } t_cell_ctrl;

endpackage

`default_nettype wire

// File: hw/rtl/mpq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module mpq_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire mpq_pkg::t_cell_ctrl i_ctrl,
    // neighbor toward the head (smaller keys)
    input  wire mpq_pkg::t_key      i_left_key,
    input  wire logic               i_left_valid,
    input  wire logic               i_left_gt,
    // neighbor toward the tail (larger keys)
    input  wire mpq_pkg::t_key      i_right_key,
    input  wire logic               i_right_valid,
    output mpq_pkg::t_key           o_key,
    output logic                    o_valid,
    output logic                    o_gt
);
    import mpq_pkg::*;

    t_key r_key;
    t_key n_key;
    logic r_valid;
    logic n_valid;

    // this cell holds a key above the new one, or is empty
    assign o_gt = !r_valid || (i_ctrl.key < r_key);

    // insert shifts toward the tail, remove shifts toward the head
    always_comb begin
        n_key   = r_key;
        n_valid = r_valid;
        if (i_ctrl.ins) begin
            if (i_left_gt) begin
                n_key = i_left_key;
            end else if (o_gt) begin
                n_key = i_ctrl.key;
            end
            n_valid = r_valid || i_left_valid;
        end else if (i_ctrl.rem) begin
            n_key   = i_right_key;
            n_valid = i_right_valid;
        end
    end

    // occupancy bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // key storage
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key   = r_key;
    assign o_valid = r_valid;

endmodule

`default_nettype wire

// File: hw/rtl/min_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// result beat: registered, shown in the cycle after its input beat is accepted
// throughput: one insert or remove per cycle unless results back up, set by the
// sorted cell chain, all keys shift together; each cell does one key compare
// reset: synchronous active-low, empties every cell; stored keys are not cleared
// and no clearing pass is needed, the block accepts beats right after reset

module min_priority_queue #(
    parameter int CAPACITY = mpq_pkg::CAPACITY_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic          i_op,
    input  wire mpq_pkg::t_key i_key_in,
    output logic               o_valid,
    input  wire logic          i_ready,
    output mpq_pkg::t_key      o_key_out,
    output logic               o_was_empty,
    output logic               o_dropped
);
    import mpq_pkg::*;

    t_key       w_key   [CAPACITY];
    logic       w_valid [CAPACITY];
    logic       w_gt    [CAPACITY];
    t_cell_ctrl w_ctrl;

    logic w_accept;
    logic w_full;
    logic w_empty;

    logic r_out_valid;
    t_key r_key_out;
    logic r_was_empty;
    logic r_dropped;

    // input beat is taken whenever the result slot is free or draining
    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign w_empty  = !w_valid[0];
    assign w_full   = w_valid[CAPACITY-1];

    // chain control
    always_comb begin
        w_ctrl.ins = w_accept && (i_op == OP_INSERT) && !w_full;
        w_ctrl.rem = w_accept && (i_op == OP_REMOVE) && !w_empty;
        w_ctrl.key = i_key_in;
    end

    // sorted cell chain, smallest key at cell 0
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_key w_lkey;
        logic w_lvalid;
        logic w_lgt;
        t_key w_rkey;
        logic w_rvalid;

        if (g == 0) begin : g_head
            assign w_lkey   = '0;
            assign w_lvalid = 1'b1;
            assign w_lgt    = 1'b0;
        end else begin : g_mid_l
            assign w_lkey   = w_key[g-1];
            assign w_lvalid = w_valid[g-1];
            assign w_lgt    = w_gt[g-1];
        end

        if (g == CAPACITY-1) begin : g_tail
            assign w_rkey   = '0;
            assign w_rvalid = 1'b0;
        end else begin : g_mid_r
            assign w_rkey   = w_key[g+1];
            assign w_rvalid = w_valid[g+1];
        end

        mpq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_left_key   (w_lkey),
            .i_left_valid (w_lvalid),
            .i_left_gt    (w_lgt),
            .i_right_key  (w_rkey),
            .i_right_valid(w_rvalid),
            .o_key        (w_key[g]),
            .o_valid      (w_valid[g]),
            .o_gt         (w_gt[g])
        );
    end

    // result beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= i_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (i_op == OP_REMOVE) begin
                r_key_out   <= w_empty ? t_key'(0) : w_key[0];
                r_was_empty <= w_empty;
                r_dropped   <= 1'b0;
            end else begin
                r_key_out   <= '0;
                r_was_empty <= 1'b0;
                r_dropped   <= w_full;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_key_out   = r_key_out;
    assign o_was_empty = r_was_empty;
    assign o_dropped   = r_dropped;

endmodule

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import mpq_pkg::*;

    localparam int QUEUE_DEPTH  = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 850;
    localparam int CALM_AFTER   = 760;     // no idling on either side past this many beats
    localparam int HOLD_AT      = 300;     // results seen before the long receiver hold
    localparam int HOLD_CYCLES  = 200;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int NUM_ROWS     = 25;

    localparam t_key KEY_MIN = 32'h8000_0000;
    localparam t_key KEY_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        t_key key_out;
        logic was_empty;
        logic dropped;
    } result_t;

    typedef struct packed {
        logic    op;
        t_key    key_in;
        logic    typed;     // use the result written in the row, not the predictor
        result_t want;
    } stim_row_t;

    typedef enum logic [1:0] {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

    // directed rows: empty queue, extremes, duplicates, key ignored on remove
    localparam stim_row_t STIM_ROWS [NUM_ROWS] = '{
        '{OP_REMOVE, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
        '{OP_REMOVE, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
        '{OP_INSERT, KEY_MAX,       1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
        '{OP_INSERT, KEY_MIN,       1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
        '{OP_INSERT, 32'h0000_0000, 1'b0, '0},
        '{OP_INSERT, 32'hFFFF_FFFF, 1'b0, '0},
        '{OP_INSERT, 32'h0000_0001, 1'b0, '0},
        '{OP_INSERT, 32'h0000_0005, 1'b0, '0},
        '{OP_INSERT, 32'h0000_0005, 1'b0, '0},
        '{OP_INSERT, 32'h0000_0005, 1'b0, '0},
        '{OP_REMOVE, 32'h1234_5678, 1'b1, '{KEY_MIN, 1'b0, 1'b0}},
        '{OP_REMOVE, 32'h0000_0000, 1'b0, '0},
        '{OP_REMOVE, 32'hFFFF_FFFF, 1'b0, '0},
        '{OP_REMOVE, 32'h0000_0000, 1'b0, '0},
        '{OP_REMOVE, 32'h0000_0000, 1'b0, '0},
        '{OP_REMOVE, 32'h0000_0000, 1'b0, '0},
        '{OP_REMOVE, 32'h0000_0000, 1'b0, '0},
        '{OP_REMOVE, 32'h0000_0000, 1'b1, '{KEY_MAX, 1'b0, 1'b0}},
        '{OP_REMOVE, 32'h0000_0000, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
        '{OP_INSERT, 32'h5555_5555, 1'b0, '0},
        '{OP_INSERT, 32'hAAAA_AAAA, 1'b0, '0},
        '{OP_INSERT, 32'h8000_0001, 1'b0, '0},
        '{OP_REMOVE, 32'h0000_0000, 1'b0, '0},
        '{OP_REMOVE, 32'h0000_0000, 1'b0, '0},
        '{OP_REMOVE, 32'h0000_0000, 1'b0, '0}
    };

    logic    i_clk      = 1'b0;
    logic    i_rst_n    = 1'b0;
    logic    i_valid    = 1'b0;
    logic    i_op       = OP_INSERT;
    t_key    i_key_in   = '0;
    logic    i_ready    = 1'b0;
    logic    o_ready;
    logic    o_valid;
    t_key    o_key_out;
    logic    o_was_empty;
    logic    o_dropped;

    // travels with the input beat so the checker knows which result to expect
    logic    note_typed = 1'b0;
    result_t note_want  = '0;

    t_key    held_keys[$];          // predicted queue contents, smallest first
    result_t pending_results[$];

    int      fail_count   = 0;
    int      results_seen = 0;
    int      cycle_count  = 0;
    bit      calm         = 1'b0;

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    min_priority_queue #(
        .CAPACITY(QUEUE_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_op       (i_op),
        .i_key_in   (i_key_in),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_key_out  (o_key_out),
        .o_was_empty(o_was_empty),
        .o_dropped  (o_dropped)
    );

    // predicted result of one operation, updating the held keys
    function automatic result_t apply_queue_op(input logic op, input t_key key);
        result_t res;
        int      pos;
        res = '0;
        pos = 0;
        if (op == OP_INSERT) begin
            if (held_keys.size() >= QUEUE_DEPTH) begin
                res.dropped = 1'b1;
            end else begin
                while (pos < held_keys.size() && held_keys[pos] <= key) pos++;
                held_keys.insert(pos, key);
            end
        end else if (held_keys.size() == 0) begin
            res.was_empty = 1'b1;
        end else begin
            res.key_out = held_keys.pop_front();
        end
        return res;
    endfunction

    // keys: wide random, small range for duplicates, extremes and their neighbors
    function automatic t_key pick_key();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 40) return t_key'($urandom);
        if (sel < 70) return t_key'(int'($urandom_range(0, 16)) - 8);
        if (sel < 80) begin
            case (sel % 4)
                0:       return KEY_MIN;
                1:       return KEY_MAX;
                2:       return t_key'(0);
                default: return t_key'(-1);
            endcase
        end
        if (sel < 90) return KEY_MIN + t_key'($urandom_range(0, 3));
        return KEY_MAX - t_key'($urandom_range(0, 3));
    endfunction

    // present one beat and hold it until accepted
    task automatic offer_beat(input logic op, input t_key key, input logic typed,
                              input result_t want);
        i_valid    <= 1'b1;
        i_op       <= op;
        i_key_in   <= key;
        note_typed <= typed;
        note_want  <= want;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // random gap on the input side
    task automatic idle_sender(input int pct);
        int n;
        if (!calm && $urandom_range(0, 99) < pct) begin
            n = $urandom_range(1, 15);
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // predict on accepted input beats, compare on accepted result beats
    always @(posedge i_clk) begin : check_beats
        result_t got;
        result_t want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                want = apply_queue_op(i_op, i_key_in);
                pending_results.push_back(note_typed ? note_want : want);
            end
            if (o_valid && i_ready) begin
                results_seen++;
                got = '{o_key_out, o_was_empty, o_dropped};
                if (pending_results.size() == 0) begin
                    $error("result beat with nothing pending: key_out %0d", got.key_out);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.key_out !== want.key_out) begin
                        $error("key_out: expected %0d, got %0d", want.key_out, got.key_out);
                        fail_count++;
                    end
                    if (got.was_empty !== want.was_empty) begin
                        $error("was_empty: expected %0b, got %0b",
                               want.was_empty, got.was_empty);
                        fail_count++;
                    end
                    if (got.dropped !== want.dropped) begin
                        $error("dropped: expected %0b, got %0b", want.dropped, got.dropped);
                        fail_count++;
                    end
                end
            end
        end
    end

    // result side: random stalls, one long hold to back up the input
    initial begin : drive_ready
        int n;
        int gap_pct;
        bit held;
        held    = 1'b0;
        gap_pct = 25;
        @(posedge i_clk);
        forever begin
            if (!held && results_seen >= HOLD_AT) begin
                held = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 99) < gap_pct) begin
                n = $urandom_range(1, 15);
                i_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end
            if ($urandom_range(0, 63) == 0)
                gap_pct = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(10, 40));
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // input side: reset, directed rows, then random phases
    initial begin : drive_input
        phase_t  mode;
        int      sent;
        int      span;
        int      gap_pct;
        int      phase_idx;
        logic    op;
        result_t none;
        none      = '0;
        sent      = 0;
        phase_idx = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (STIM_ROWS[r]) begin
            offer_beat(STIM_ROWS[r].op, STIM_ROWS[r].key_in, STIM_ROWS[r].typed,
                       STIM_ROWS[r].want);
            idle_sender(20);
        end

        // open with a fill to overflow and a drain to empty, then mix
        while (sent < RANDOM_ITEMS) begin
            if (phase_idx == 0) begin
                mode = PH_FILL;
                span = 110;
            end else if (phase_idx == 1) begin
                mode = PH_DRAIN;
                span = 110;
            end else begin
                mode = phase_t'($urandom_range(0, 2));
                span = $urandom_range(30, 120);
            end
            phase_idx++;
            gap_pct = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(10, 40));
            for (int k = 0; k < span && sent < RANDOM_ITEMS; k++) begin
                case (mode)
                    PH_FILL:  op = ($urandom_range(0, 9) == 0) ? OP_REMOVE : OP_INSERT;
                    PH_DRAIN: op = ($urandom_range(0, 9) == 0) ? OP_INSERT : OP_REMOVE;
                    default:  op = ($urandom_range(0, 1) == 0) ? OP_INSERT : OP_REMOVE;
                endcase
                offer_beat(op, pick_key(), 1'b0, none);
                sent++;
                if (sent >= CALM_AFTER) calm = 1'b1;
                idle_sender(gap_pct);
            end
        end

        // drain outstanding results, then idle before reporting
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/mpq_pkg.sv
hw/rtl/mpq_cell.sv
hw/rtl/min_priority_queue.sv
sim/tb.sv
